### sv/bbe_pkg.sv
// Shared types and constants of the edge-aware 3x3 box blur.
// No dependencies; the channel interfaces and the top level import it.
package bbe_pkg;

  // Frame limits and the line store geometry
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Configuration register data and index
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  // Compare width: holds any register value and any counter plus one
  localparam int unsigned CNT_W      = CFG_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Neighbors that fall outside the frame for one output pixel
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } nbr_mask_t;

  // Rounded mean: floor((sum + count/2) / count) as (y * K) >> DIV_SHIFT
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned Y_W       = 12;
  localparam int unsigned K_W       = 15;
  localparam int unsigned DIV_SHIFT = 14;
  localparam logic [K_W-1:0] K_ONE   = K_W'(16384);
  localparam logic [K_W-1:0] K_THIRD = K_W'(5462);
  localparam logic [K_W-1:0] K_NINTH = K_W'(1821);

endpackage

### sv/bbe_intf.sv
// Channel interfaces of the box blur: pixel input, blurred result, config writes.
// Depends on bbe_pkg for the payload types.
interface bbe_pix_if;
  import bbe_pkg::*;
  logic  valid;
  logic  ready;
  logic  mode;
  chan_t pixel_red;
  chan_t pixel_green;
  chan_t pixel_blue;
  modport source (output valid, mode, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, mode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface bbe_blur_if;
  import bbe_pkg::*;
  logic  valid;
  logic  ready;
  chan_t blur_red;
  chan_t blur_green;
  chan_t blur_blue;
  logic  frame_end;
  modport source (output valid, blur_red, blur_green, blur_blue, frame_end, input ready);
  modport sink   (input valid, blur_red, blur_green, blur_blue, frame_end, output ready);
endinterface

interface bbe_cfg_if;
  import bbe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/box_blur_3x3_edge_aware.sv
// Edge-aware 3x3 box blur of an RGB raster stream; one pixel beat per clock unless
// output back-pressure stalls the pipe. A beat that completes a result goes through the
// line store read (stage A), the sum (stage B) and the scale into the output register.
// Output pixel k of a frame completes on input beat k + frame_width + 1.
// Reset (synchronous, rst_n low): counters, window and pipeline valids clear,
// frame size returns to 1024x1024; the line stores keep their contents.
module box_blur_3x3_edge_aware (
  input  logic        clk,
  input  logic        rst_n,
  bbe_pix_if.sink     in_pix,
  bbe_blur_if.source  out_pix,
  bbe_cfg_if.sink     cfg_wr
);
  import bbe_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] w_eff, h_eff;

  // Position counters
  logic [COL_W-1:0] in_col_r;
  logic [ROW_W:0]   in_row_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;

  // Accept-side decode
  logic             accept, draining, ignore, a_load, emit, last;
  logic [CNT_W-1:0] in_col_inc, out_col_inc, out_row_inc;
  logic             col_wrap;
  nbr_mask_t        mask;

  // Stage A: line store read
  logic             a_v_r, a_wr_r, a_emit_r, a_last_r, a_fwd_r;
  logic [COL_W-1:0] a_col_r;
  rgb_t             a_bot_r, a_fwd_top_r, a_fwd_mid_r;
  nbr_mask_t        a_mask_r;
  rgb_t             up_rd_r, lo_rd_r;
  rgb_t             a_top, a_mid;
  logic             a_move, a_fwd;

  rgb_t             upper_mem [MAX_WIDTH];
  rgb_t             lower_mem [MAX_WIDTH];

  // Window and stage B: sums and scale factor
  rgb_t             win_r [9];
  rgb_t             win_nxt [9];
  logic [SUM_W-1:0] s_red, s_green, s_blue;
  logic [1:0]       n_rows, n_cols;
  logic [3:0]       cnt;
  logic [K_W-1:0]   k_nxt;
  logic             b_v_r, b_last_r, b_free, b_move;
  logic [Y_W-1:0]   b_yr_r, b_yg_r, b_yb_r;
  logic [K_W-1:0]   b_k_r;

  // Output register
  logic             out_v_r, out_free, out_end_r;
  chan_t            out_red_r, out_green_r, out_blue_r;
  logic [Y_W+K_W-1:0] p_red, p_green, p_blue;

  // Round-half-up pre-offset and pre-shift for each neighbor count
  function automatic logic [Y_W-1:0] prep_y(input logic [SUM_W-1:0] s, input logic [3:0] c);
    logic [Y_W-1:0] sx;
    sx = Y_W'(s);
    case (c)
      4'd2:    prep_y = (sx + Y_W'(1)) >> 1;
      4'd3:    prep_y = sx + Y_W'(1);
      4'd4:    prep_y = (sx + Y_W'(2)) >> 2;
      4'd6:    prep_y = (sx + Y_W'(3)) >> 1;
      4'd9:    prep_y = sx + Y_W'(4);
      default: prep_y = sx;
    endcase
  endfunction

  // Clamp the register values to the usable frame size
  assign w_eff = (width_r == '0) ? CNT_W'(1) :
                 (CNT_W'(width_r) > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(width_r);
  assign h_eff = (height_r == '0) ? CNT_W'(1) :
                 (CNT_W'(height_r) > CNT_W'(MAX_HEIGHT)) ? CNT_W'(MAX_HEIGHT) : CNT_W'(height_r);

  // Configuration writes
  assign cfg_wr.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_WIDTH);
      height_r <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH:  width_r  <= cfg_wr.data;
        REG_FRAME_HEIGHT: height_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline advance
  assign out_free     = !out_v_r || out_pix.ready;
  assign b_move       = b_v_r && out_free;
  assign b_free       = !b_v_r || b_move;
  assign a_move       = a_v_r && (!a_emit_r || b_free);
  assign in_pix.ready = rst_n && (!a_v_r || a_move);
  assign accept       = in_pix.valid && in_pix.ready;

  // Decode the incoming beat against the counters
  assign draining    = CNT_W'(in_row_r) >= h_eff;
  assign ignore      = !draining && in_pix.mode;
  assign a_load      = accept && !ignore;
  assign emit        = (in_row_r >= (ROW_W+1)'(2)) ||
                       ((in_row_r == (ROW_W+1)'(1)) && (in_col_r != '0));
  assign in_col_inc  = CNT_W'(in_col_r) + CNT_W'(1);
  assign col_wrap    = in_col_inc >= w_eff;
  assign out_col_inc = CNT_W'(out_col_r) + CNT_W'(1);
  assign out_row_inc = CNT_W'(out_row_r) + CNT_W'(1);
  assign mask.top    = out_row_r == '0;
  assign mask.bot    = out_row_inc >= h_eff;
  assign mask.left   = out_col_r == '0;
  assign mask.right  = out_col_inc >= w_eff;
  assign last        = mask.bot && mask.right;

  // Advance the input and output positions; restart after the last output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (a_load) begin
      if (emit && last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (col_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + (ROW_W+1)'(1);
        end else begin
          in_col_r <= COL_W'(in_col_inc);
        end
        if (emit) begin
          if (mask.right) begin
            out_col_r <= '0;
            out_row_r <= ROW_W'(out_row_inc);
          end else begin
            out_col_r <= COL_W'(out_col_inc);
          end
        end
      end
    end
  end

  // Forward the previous column's write when it lands on the address being read
  assign a_fwd = a_move && a_wr_r && (a_col_r == in_col_r);
  assign a_top = a_fwd_r ? a_fwd_top_r : up_rd_r;
  assign a_mid = a_fwd_r ? a_fwd_mid_r : lo_rd_r;

  // Line stores: read on load, shift the column up one row when stage A leaves
  always_ff @(posedge clk) begin
    if (a_load) begin
      up_rd_r <= upper_mem[in_col_r];
      lo_rd_r <= lower_mem[in_col_r];
    end
    if (a_move && a_wr_r) begin
      upper_mem[a_col_r] <= a_mid;
      lower_mem[a_col_r] <= a_bot_r;
    end
  end

  // Stage A control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_load) begin
      a_v_r <= 1'b1;
    end else if (a_move) begin
      a_v_r <= 1'b0;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_col_r     <= in_col_r;
      a_wr_r      <= !draining;
      a_bot_r     <= draining ? rgb_t'('0) :
                     rgb_t'{red: in_pix.pixel_red, green: in_pix.pixel_green,
                            blue: in_pix.pixel_blue};
      a_emit_r    <= emit;
      a_last_r    <= last;
      a_mask_r    <= mask;
      a_fwd_r     <= a_fwd;
      a_fwd_top_r <= a_mid;
      a_fwd_mid_r <= a_bot_r;
    end
  end

  // Shift the window left and take in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = a_top;
    win_nxt[5] = a_mid;
    win_nxt[8] = a_bot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (a_move) begin
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
    end
  end

  // Sum the in-frame neighbors and pick the scale factor
  always_comb begin
    s_red   = '0;
    s_green = '0;
    s_blue  = '0;
    for (int i = 0; i < 9; i++) begin
      if (!((i / 3 == 0) && a_mask_r.top) && !((i / 3 == 2) && a_mask_r.bot) &&
          !((i % 3 == 0) && a_mask_r.left) && !((i % 3 == 2) && a_mask_r.right)) begin
        s_red   = s_red   + SUM_W'(win_nxt[i].red);
        s_green = s_green + SUM_W'(win_nxt[i].green);
        s_blue  = s_blue  + SUM_W'(win_nxt[i].blue);
      end
    end
    n_rows = 2'd3 - 2'(a_mask_r.top) - 2'(a_mask_r.bot);
    n_cols = 2'd3 - 2'(a_mask_r.left) - 2'(a_mask_r.right);
    cnt    = 4'(n_rows) * 4'(n_cols);
    case (cnt)
      4'd3, 4'd6: k_nxt = K_THIRD;
      4'd9:       k_nxt = K_NINTH;
      default:    k_nxt = K_ONE;
    endcase
  end

  // Stage B control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (a_move && a_emit_r) begin
      b_v_r <= 1'b1;
    end else if (b_move) begin
      b_v_r <= 1'b0;
    end
  end

  // Stage B payload
  always_ff @(posedge clk) begin
    if (a_move && a_emit_r) begin
      b_yr_r   <= prep_y(s_red, cnt);
      b_yg_r   <= prep_y(s_green, cnt);
      b_yb_r   <= prep_y(s_blue, cnt);
      b_k_r    <= k_nxt;
      b_last_r <= a_last_r;
    end
  end

  // Scale by the reciprocal of the count
  assign p_red   = (Y_W+K_W)'(b_yr_r) * (Y_W+K_W)'(b_k_r);
  assign p_green = (Y_W+K_W)'(b_yg_r) * (Y_W+K_W)'(b_k_r);
  assign p_blue  = (Y_W+K_W)'(b_yb_r) * (Y_W+K_W)'(b_k_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (b_move) begin
      out_v_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_red_r   <= p_red[DIV_SHIFT +: 8];
      out_green_r <= p_green[DIV_SHIFT +: 8];
      out_blue_r  <= p_blue[DIV_SHIFT +: 8];
      out_end_r   <= b_last_r;
    end
  end

  assign out_pix.valid      = out_v_r;
  assign out_pix.blur_red   = out_red_r;
  assign out_pix.blur_green = out_green_r;
  assign out_pix.blur_blue  = out_blue_r;
  assign out_pix.frame_end  = out_end_r;

  // A stalled stage A keeps its column and its place in the pipe
  a_hold_chk: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !a_move |=> a_v_r && $stable(a_col_r))
    else $error("stage A lost or changed a stalled beat");

  // A stalled stage B keeps its scale factor and its red operand
  b_hold_chk: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !b_move |=> b_v_r && $stable(b_k_r) && $stable(b_yr_r))
    else $error("stage B lost or changed a stalled beat");

  // Scale factor is always one of the three reciprocals
  k_code_chk: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> (b_k_r == K_ONE || b_k_r == K_THIRD || b_k_r == K_NINTH))
    else $error("invalid scale factor in stage B");

  // Reset empties the whole pipe
  rst_chk: assert property (@(posedge clk)
    !rst_n |=> !a_v_r && !b_v_r && !out_v_r)
    else $error("pipeline not empty after reset");

endmodule

### verif/box_blur_3x3_edge_aware_checker.sv
// Result checker of the edge-aware 3x3 box blur: predicts every blurred pixel
// from the accepted input and config beats and compares the output beats.
// Depends on bbe_pkg and the channel interfaces in bbe_intf.
module box_blur_3x3_edge_aware_checker
  import bbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bbe_pix_if          pix,
  bbe_blur_if         blur,
  bbe_cfg_if          cfg,
  output int unsigned fail_count,
  output int unsigned blur_due_count
);

  localparam logic        BEAT_FLUSH  = 1'b1;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    rgb_t px;
    logic frame_end;
  } blur_beat_t;

  // Predictor state: frame size, line stores, window and raster counters
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  rgb_t             upper_line [MAX_WIDTH];
  rgb_t             lower_line [MAX_WIDTH];
  rgb_t             win [9];
  logic [CNT_W-1:0] in_col;
  logic [CNT_W-1:0] in_row;
  logic [CNT_W-1:0] out_col;
  logic [CNT_W-1:0] out_row;
  blur_beat_t       blur_due_q [$];

  initial begin
    fail_count     = 0;
    blur_due_count = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Clamp a size register to the range the block works with
  function automatic logic [CNT_W-1:0] dim_in_use(input logic [CFG_W-1:0] v,
                                                   input int unsigned maxv);
    if (v == 0) return CNT_W'(1);
    if (v > maxv) return CNT_W'(maxv);
    return CNT_W'(v);
  endfunction

  // Round half up: (2*sum + n) / (2*n)
  function automatic chan_t rounded_mean(input logic [SUM_W-1:0] s, input logic [3:0] n);
    int unsigned num;
    int unsigned den;
    num = 2 * s + n;
    den = 2 * n;
    return chan_t'(num / den);
  endfunction

  // Advance the predicted window by one input beat and queue any blurred pixel
  task automatic take_pixel_beat(input logic beat_mode, input rgb_t px);
    logic [CNT_W-1:0] w;
    logic [CNT_W-1:0] h;
    logic [CNT_W-1:0] col;
    rgb_t             top_px;
    rgb_t             mid_px;
    rgb_t             bot_px;
    rgb_t             p;
    logic             draining;
    logic             emit;
    logic             last;
    logic [SUM_W-1:0] sr;
    logic [SUM_W-1:0] sg;
    logic [SUM_W-1:0] sb;
    logic [3:0]       count;
    int               r;
    int               c;
    blur_beat_t       res;
    w = dim_in_use(width_reg, MAX_WIDTH);
    h = dim_in_use(height_reg, MAX_HEIGHT);
    draining = (in_row >= h);
    // drop a flush while pixels are still due
    if (!draining && beat_mode == BEAT_FLUSH) return;
    col    = in_col;
    top_px = '0;
    mid_px = '0;
    bot_px = '0;
    if (col < MAX_WIDTH) begin
      top_px = upper_line[col];
      mid_px = lower_line[col];
      if (!draining) begin
        bot_px          = px;
        upper_line[col] = mid_px;
        lower_line[col] = bot_px;
      end
    end
    // shift the window left and load the new column
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = bot_px;

    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col = in_col + 1'b1;
    if (in_col >= w) begin
      in_col = '0;
      in_row = in_row + 1'b1;
    end
    if (!emit) return;

    // sum the neighbors that lie inside the frame
    sr    = '0;
    sg    = '0;
    sb    = '0;
    count = '0;
    for (r = 0; r < 3; r++) begin
      if (r == 0 && out_row == 0) continue;
      if (r == 2 && out_row + 1 >= h) continue;
      for (c = 0; c < 3; c++) begin
        if (c == 0 && out_col == 0) continue;
        if (c == 2 && out_col + 1 >= w) continue;
        p     = win[r*3+c];
        sr    = sr + p.red;
        sg    = sg + p.green;
        sb    = sb + p.blue;
        count = count + 1'b1;
      end
    end
    last = (out_row + 1 >= h) && (out_col + 1 >= w);

    res.px.red    = rounded_mean(sr, count);
    res.px.green  = rounded_mean(sg, count);
    res.px.blue   = rounded_mean(sb, count);
    res.frame_end = last;
    blur_due_q.push_back(res);

    // restart the frame after its last pixel
    if (last) begin
      out_col = '0;
      out_row = '0;
      in_col  = '0;
      in_row  = '0;
    end else begin
      out_col = out_col + 1'b1;
      if (out_col >= w) begin
        out_col = '0;
        out_row = out_row + 1'b1;
      end
    end
  endtask

  // Compare one output beat with the oldest blurred pixel due
  task automatic check_blur_beat();
    blur_beat_t want;
    if (blur_due_q.size() == 0) begin
      report_mismatch($sformatf("pixel %02x %02x %02x arrived with none due",
                                blur.blur_red, blur.blur_green, blur.blur_blue));
      return;
    end
    want = blur_due_q.pop_front();
    if (blur.blur_red !== want.px.red)
      report_mismatch($sformatf("red got %0d want %0d", blur.blur_red, want.px.red));
    if (blur.blur_green !== want.px.green)
      report_mismatch($sformatf("green got %0d want %0d", blur.blur_green, want.px.green));
    if (blur.blur_blue !== want.px.blue)
      report_mismatch($sformatf("blue got %0d want %0d", blur.blur_blue, want.px.blue));
    if (blur.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end got %0b want %0b", blur.frame_end, want.frame_end));
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
      blur_due_q.delete();
    end else begin
      if (blur.valid && blur.ready) check_blur_beat();
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_FRAME_WIDTH) width_reg = cfg.data;
        else height_reg = cfg.data;
      end
      if (pix.valid && pix.ready)
        take_pixel_beat(pix.mode, {pix.pixel_red, pix.pixel_green, pix.pixel_blue});
    end
    blur_due_count = blur_due_q.size();
  end

endmodule

### verif/box_blur_3x3_edge_aware_test.sv
// Testbench top of the edge-aware 3x3 box blur: clock, reset, frame stimulus,
// config writes, output back-pressure and the verdict.
// Depends on bbe_pkg, bbe_intf, the block and box_blur_3x3_edge_aware_checker.
module box_blur_3x3_edge_aware_test;
  import bbe_pkg::*;

  localparam int unsigned HALF_PERIOD     = 6;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned LIMIT_CYCLES    = 500000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_ITEMS    = 1650;
  localparam logic        BEAT_PIXEL      = 1'b0;
  localparam logic        BEAT_FLUSH      = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned blur_fail_count;
  int unsigned blur_due_count;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned fed_items = 0;
  int unsigned plan_w = MAX_WIDTH;
  int unsigned plan_h = MAX_HEIGHT;
  int unsigned cycle_count = 0;

  bbe_pix_if  pix_ch ();
  bbe_blur_if blur_ch ();
  bbe_cfg_if  cfg_ch ();

  box_blur_3x3_edge_aware u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_pix (blur_ch),
    .cfg_wr  (cfg_ch)
  );

  box_blur_3x3_edge_aware_checker u_blur_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix            (pix_ch),
    .blur           (blur_ch),
    .cfg            (cfg_ch),
    .fail_count     (blur_fail_count),
    .blur_due_count (blur_due_count)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // End the run if it stalls
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Output back-pressure: random idling, plus a long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen     = 0;
    hold_left     = 0;
    blur_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        blur_ch.ready <= 1'b0;
      end else begin
        blur_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v,
                                             input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Random pixel, sometimes pinned to the channel extremes
  function automatic rgb_t rand_px();
    rgb_t p;
    p = rgb_t'(24'($urandom));
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      2: p.green = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  // Offer one input beat after a random gap; return at the falling edge after it is taken
  task automatic push_beat(input logic beat_mode, input rgb_t px, input bit counted);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.mode        <= beat_mode;
    pix_ch.pixel_red   <= px.red;
    pix_ch.pixel_green <= px.green;
    pix_ch.pixel_blue  <= px.blue;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
    if (counted) fed_items++;
  endtask

  // Hold the input until every blurred pixel due has left, then let the pipe settle
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    while (blur_due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) plan_w = dim_in_use(val, MAX_WIDTH);
    else plan_h = dim_in_use(val, MAX_HEIGHT);
  endtask

  // One frame in raster order plus its drain, with ignored flushes mixed in.
  // With regrow set, the height changes at a row boundary to a value past that row.
  task automatic send_frame(input bit regrow);
    int unsigned r;
    int unsigned c;
    int unsigned rows;
    int unsigned cut_at;
    rows   = plan_h;
    cut_at = regrow ? $urandom_range(rows - 1, 0) : rows;
    r      = 0;
    while (r < rows) begin
      if (r == cut_at) begin
        write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(r + 6, r + 1)));
        rows = plan_h;
      end
      for (c = 0; c < plan_w; c++) begin
        if ($urandom_range(99) < 4) push_beat(BEAT_FLUSH, rand_px(), 1'b0);
        push_beat(BEAT_PIXEL, rand_px(), 1'b1);
      end
      r++;
    end
    // drain: a pixel here acts as a flush
    for (c = 0; c <= plan_w; c++) begin
      if ($urandom_range(99) < 15) push_beat(BEAT_PIXEL, rand_px(), 1'b1);
      else push_beat(BEAT_FLUSH, rand_px(), 1'b1);
    end
    // the frame has restarted, so a stray flush is dropped
    if ($urandom_range(99) < 10) push_beat(BEAT_FLUSH, rand_px(), 1'b0);
  endtask

  // Stimulus and verdict
  initial begin
    logic [23:0] corner_px [12];
    int unsigned phase;
    int unsigned phase_start;
    int unsigned i;
    bit          force_both;
    corner_px = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                  24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080,
                  24'h010101, 24'hFEFEFE, 24'h7F807F, 24'hFFFFFF};
    rst_n              = 1'b0;
    pix_ch.valid       = 1'b0;
    pix_ch.mode        = BEAT_PIXEL;
    pix_ch.pixel_red   = '0;
    pix_ch.pixel_green = '0;
    pix_ch.pixel_blue  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_FRAME_WIDTH;
    cfg_ch.data        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 4x3 frame of extreme pixels, a flush while pixels are due,
    // a pixel during the drain and a flush after the frame restarts
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    for (i = 0; i < 12; i++) begin
      if (i == 5) push_beat(BEAT_FLUSH, rgb_t'(24'hFFFFFF), 1'b0);
      push_beat(BEAT_PIXEL, rgb_t'(corner_px[i]), 1'b1);
    end
    for (i = 0; i < 5; i++) begin
      if (i == 1) push_beat(BEAT_PIXEL, rgb_t'(24'hA5A5A5), 1'b1);
      else push_beat(BEAT_FLUSH, rgb_t'(24'h5A5A5A), 1'b1);
    end
    push_beat(BEAT_FLUSH, rgb_t'(24'h000000), 1'b0);

    // Directed: height shrinks below the current row mid-frame, ending the frame early
    write_reg(REG_FRAME_WIDTH, CFG_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    for (i = 0; i < 4; i++) push_beat(BEAT_PIXEL, rand_px(), 1'b1);
    write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
    push_beat(BEAT_FLUSH, rand_px(), 1'b1);

    // Random frames in three idling regimes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 20;
          snk_idle_pct = 47;
        end
        1: begin
          src_idle_pct = 47;
          snk_idle_pct = 20;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase

      // one size extreme per regime; the last one fills the block under a hold-off
      case (phase)
        0: begin
          write_reg(REG_FRAME_WIDTH,
                    $urandom_range(1) ? CFG_W'(1024) : CFG_W'($urandom_range(2047, 1025)));
          write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
        end
        1: begin
          write_reg(REG_FRAME_WIDTH, CFG_W'(0));
          write_reg(REG_FRAME_HEIGHT,
                    $urandom_range(1) ? CFG_W'(1024) : CFG_W'($urandom_range(2047, 1025)));
        end
        default: begin
          write_reg(REG_FRAME_WIDTH, CFG_W'(24));
          write_reg(REG_FRAME_HEIGHT, CFG_W'(10));
          hold_token++;
        end
      endcase
      send_frame(1'b0);

      phase_start = fed_items;
      while (fed_items - phase_start < RANDOM_ITEMS / 3) begin
        force_both = (plan_w * plan_h > 400);
        if (force_both || $urandom_range(1)) begin
          case ($urandom_range(19))
            0:       write_reg(REG_FRAME_WIDTH, CFG_W'(0));
            1:       write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(40, 13)));
            default: write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(12, 1)));
          endcase
        end
        if (force_both || $urandom_range(1)) begin
          if ($urandom_range(9) == 0) write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
          else write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(9, 1)));
        end
        send_frame($urandom_range(99) < 8);
      end
      wait_drained();
    end

    // Let stragglers show up before the verdict
    repeat (20) @(negedge clk);
    if (blur_fail_count == 0 && blur_due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
